[rtl/core/zbp_pkg.sv]
// Package for the zeromer background predictor.
// Fixed field widths and reset constants; no dependencies.
package zbp_pkg;

   localparam int TIME_BITS = 24;
   localparam int TAU_BITS  = 16;
   localparam int CORR_BITS = 32;
   // taue/taub + dt never reach 2^25
   localparam int MULT_BITS = TIME_BITS + 1;

   localparam logic [TAU_BITS-1:0] TAUE_RESET = 16'd256;

endpackage

[rtl/core/zbp_req_if.sv]
// Input channel interface: one frame of a well trace per transaction.
// Depends on zbp_pkg for the timestamp and time constant widths.
interface zbp_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                             valid;
   logic                             ready;
   logic signed [SAMPLE_BITS-1:0]    ref_sample;
   logic [zbp_pkg::TIME_BITS-1:0]    frame_time;
   logic [zbp_pkg::TAU_BITS-1:0]     well_taub;
   logic                             last_frame;

   modport source (output valid, ref_sample, frame_time, well_taub, last_frame,
                   input ready);
   modport sink   (input valid, ref_sample, frame_time, well_taub, last_frame,
                   output ready);
endinterface

[rtl/core/zbp_rsp_if.sv]
// Result channel interface: one zeromer estimate per transaction.
// No package dependency.
interface zbp_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] zeromer_estimate;
   logic                          divide_fault;
   logic                          saturated;

   modport source (output valid, zeromer_estimate, divide_fault, saturated,
                   input ready);
   modport sink   (input valid, zeromer_estimate, divide_fault, saturated,
                   output ready);
endinterface

[rtl/core/zeromer_background_predict.sv]
// Zeromer background predictor top level: trace state, sequencer, output register.
// Depends on zbp_pkg, zbp_req_if, zbp_rsp_if, zbp_serial_mult, zbp_serial_div.
//
//  channel | direction | handshake          | payload
//  req     | in        | valid/ready        | ref_sample, frame_time, well_taub, last_frame
//  rsp     | out       | valid/ready        | zeromer_estimate, divide_fault, saturated
//  csr     | in        | csr_write_enable   | csr_write_data = taue_estimate
//
// The first frame of a trace goes from accept straight to the finish state. Later
// frames run a serial multiply over MULT_BITS (25) multiplier bits and then a serial
// divide over PROD_BITS (50 at default widths) quotient bits; a zero divisor skips
// the divide. One frame is in work at a time; the next is accepted
// while a result waits in the output register. Reset is synchronous and clears
// the trace state; taue_estimate returns to 256 (TAUE_RESET).
module zeromer_background_predict #(
   parameter int FRACTION_BITS = 8,
   parameter int SAMPLE_BITS   = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [zbp_pkg::TAU_BITS-1:0]    csr_write_data,
   zbp_req_if.sink                         req,
   zbp_rsp_if.source                       rsp
);
   localparam int TB = zbp_pkg::TIME_BITS;
   localparam int MB = zbp_pkg::MULT_BITS;
   localparam int CB = zbp_pkg::CORR_BITS;
   localparam int PROD_BITS = ((SAMPLE_BITS + MB > CB + FRACTION_BITS) ?
                               SAMPLE_BITS + MB : CB + FRACTION_BITS) + 1;
   localparam int SUM_BITS  = ((SAMPLE_BITS > CB) ? SAMPLE_BITS : CB) + 2;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MULT   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [PROD_BITS-1:0] QPOS =
      {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [PROD_BITS-1:0] QNEG =
      {{(PROD_BITS-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0] CMAX =
      {{(SUM_BITS-CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] CMIN =
      {{(SUM_BITS-CB+1){1'b1}}, {(CB-1){1'b0}}};

   logic [1:0]                    state_ff, state_in;
   logic [zbp_pkg::TAU_BITS-1:0]  taue_ff, taue_in;
   logic signed [CB-1:0]          corr_ff, corr_in;
   logic [TB-1:0]                 prev_ff, prev_in;
   logic                          start_ff, start_in;    // trace_start
   logic signed [SAMPLE_BITS-1:0] ref_ff, ref_in;
   logic [TB-1:0]                 now_ff, now_in;
   logic                          last_ff, last_in;
   logic                          first_ff, first_in;
   logic [MB-1:0]                 dsr_ff, dsr_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_est_ff, rsp_est_in;
   logic                          rsp_fault_ff, rsp_fault_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic                          accept;
   logic [TB-1:0]                 dt;
   logic [MB-1:0]                 mult_val;
   logic                          mult_start;
   logic                          div_start;
   logic signed [PROD_BITS-1:0]   addend;
   logic signed [PROD_BITS-1:0]   product;
   logic                          mult_done;
   logic [PROD_BITS-1:0]          num_mag;
   logic [PROD_BITS-1:0]          quotient;
   logic                          div_done;
   logic                          fault;
   logic signed [SAMPLE_BITS-1:0] est;
   logic                          q_sat;
   logic signed [SUM_BITS-1:0]    corr_sum;
   logic signed [CB-1:0]          corr_next;
   logic                          c_sat;

   assign req.ready        = (state_ff == S_IDLE);
   assign accept           = req.valid && req.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.zeromer_estimate = rsp_est_ff;
   assign rsp.divide_fault = rsp_fault_ff;
   assign rsp.saturated    = rsp_sat_ff;

   assign dt         = req.frame_time - prev_ff;
   assign mult_val   = {{(MB-zbp_pkg::TAU_BITS){1'b0}}, taue_ff} + {1'b0, dt};
   assign dsr_in     = accept ? ({{(MB-zbp_pkg::TAU_BITS){1'b0}}, req.well_taub} + {1'b0, dt})
                              : dsr_ff;
   assign mult_start = accept && !start_ff;
   assign addend     = {{(PROD_BITS-CB-FRACTION_BITS){corr_ff[CB-1]}}, corr_ff,
                        {FRACTION_BITS{1'b0}}};
   assign fault      = (dsr_ff == '0);
   assign num_mag    = product[PROD_BITS-1] ? (~product + 1'b1) : product;
   assign neg_in     = mult_done ? product[PROD_BITS-1] : neg_ff;
   assign div_start  = (state_ff == S_MULT) && mult_done && !fault;

   zbp_serial_mult #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PROD_BITS   (PROD_BITS)
   ) u_mult (
      .clock        (clock),
      .reset        (reset),
      .start        (mult_start),
      .multiplicand (req.ref_sample),
      .multiplier   (mult_val),
      .addend       (addend),
      .product      (product),
      .done         (mult_done)
   );

   zbp_serial_div #(
      .DIVIDEND_BITS (PROD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (dsr_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Quotient clip to the sample range; sign comes from the numerator.
   always_comb begin
      q_sat = 1'b0;
      est   = '0;
      if (!first_ff && !fault) begin
         if (neg_ff) begin
            if (quotient > QNEG) begin
               q_sat = 1'b1;
               est   = $signed(QNEG[SAMPLE_BITS-1:0]);
            end else begin
               est   = -$signed(quotient[SAMPLE_BITS-1:0]);
            end
         end else if (quotient > QPOS) begin
            q_sat = 1'b1;
            est   = $signed(QPOS[SAMPLE_BITS-1:0]);
         end else begin
            est   = $signed(quotient[SAMPLE_BITS-1:0]);
         end
      end
   end

   always_comb begin
      corr_sum = $signed({{(SUM_BITS-CB){corr_ff[CB-1]}}, corr_ff})
               + $signed({{(SUM_BITS-SAMPLE_BITS){ref_ff[SAMPLE_BITS-1]}}, ref_ff})
               - $signed({{(SUM_BITS-SAMPLE_BITS){est[SAMPLE_BITS-1]}}, est});
      c_sat = 1'b0;
      if (corr_sum > CMAX) begin
         c_sat     = 1'b1;
         corr_next = CMAX[CB-1:0];
      end else if (corr_sum < CMIN) begin
         c_sat     = 1'b1;
         corr_next = CMIN[CB-1:0];
      end else begin
         corr_next = corr_sum[CB-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      taue_in      = csr_write_enable ? csr_write_data : taue_ff;
      corr_in      = corr_ff;
      prev_in      = prev_ff;
      start_in     = start_ff;
      ref_in       = ref_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_est_in   = rsp_est_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ref_in   = req.ref_sample;
               now_in   = req.frame_time;
               last_in  = req.last_frame;
               first_in = start_ff;
               state_in = start_ff ? S_FINISH : S_MULT;
            end
         end
         S_MULT: begin
            if (mult_done) begin
               state_in = fault ? S_FINISH : S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est;
               rsp_fault_in = !first_ff && fault;
               rsp_sat_in   = !first_ff && (q_sat || c_sat);
               if (!first_ff) begin
                  corr_in = corr_next;
               end
               if (last_ff) begin
                  corr_in  = '0;
                  prev_in  = '0;
                  start_in = 1'b1;
               end else begin
                  prev_in  = now_ff;
                  start_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         taue_ff      <= zbp_pkg::TAUE_RESET;
         corr_ff      <= '0;
         prev_ff      <= '0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taue_ff      <= taue_in;
         corr_ff      <= corr_in;
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff       <= ref_in;
      now_ff       <= now_in;
      last_ff      <= last_in;
      first_ff     <= first_in;
      dsr_ff       <= dsr_in;
      neg_ff       <= neg_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_sat_ff   <= rsp_sat_in;
   end
endmodule

[rtl/core/zbp_serial_mult.sv]
// Bit-serial shift-add multiplier: addend + multiplicand * multiplier,
// one multiplier bit per cycle, LSB first. Depends on zbp_pkg.
module zbp_serial_mult #(
   parameter int SAMPLE_BITS = 24,
   parameter int PROD_BITS   = 50
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [SAMPLE_BITS-1:0]        multiplicand,
   input  logic [zbp_pkg::MULT_BITS-1:0]        multiplier,
   input  logic signed [PROD_BITS-1:0]          addend,
   output logic signed [PROD_BITS-1:0]          product,
   output logic                                 done
);
   localparam int CNT_BITS = $clog2(zbp_pkg::MULT_BITS);

   logic signed [PROD_BITS-1:0]   acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]   mcand_ff;
   logic [zbp_pkg::MULT_BITS-1:0] mplr_ff;
   logic [CNT_BITS-1:0]           count_ff;
   logic                          busy_ff;
   logic                          done_ff;

   assign acc_in  = acc_ff + (mplr_ff[0] ? mcand_ff : '0);
   assign product = acc_ff;
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (count_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (count_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= addend;
         mcand_ff <= {{(PROD_BITS-SAMPLE_BITS){multiplicand[SAMPLE_BITS-1]}}, multiplicand};
         mplr_ff  <= multiplier;
         count_ff <= CNT_BITS'(zbp_pkg::MULT_BITS - 1);
      end else if (busy_ff) begin
         acc_ff   <= acc_in;
         mcand_ff <= mcand_ff <<< 1;
         mplr_ff  <= mplr_ff >> 1;
         count_ff <= count_ff - 1'b1;
      end
   end
endmodule

[rtl/core/zbp_serial_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, MSB first.
// Unsigned dividend and divisor; depends on zbp_pkg for the divisor width.
module zbp_serial_div #(
   parameter int DIVIDEND_BITS = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIVIDEND_BITS-1:0]          dividend,
   input  logic [zbp_pkg::MULT_BITS-1:0]     divisor,
   output logic [DIVIDEND_BITS-1:0]          quotient,
   output logic                              done
);
   localparam int DW       = zbp_pkg::MULT_BITS;
   localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

   logic [DIVIDEND_BITS-1:0] dvd_ff;      // dividend bits out, quotient bits in
   logic [DW-1:0]            rem_ff;
   logic [DW-1:0]            dsr_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DW:0]              rem_shift;
   logic [DW:0]              diff;
   logic                     qbit;

   assign rem_shift = {rem_ff, dvd_ff[DIVIDEND_BITS-1]};
   assign diff      = rem_shift - {1'b0, dsr_ff};
   assign qbit      = !diff[DW];
   assign quotient  = dvd_ff;
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (count_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (count_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff   <= dividend;
         rem_ff   <= '0;
         dsr_ff   <= divisor;
         count_ff <= CNT_BITS'(DIVIDEND_BITS - 1);
      end else if (busy_ff) begin
         rem_ff   <= qbit ? diff[DW-1:0] : rem_shift[DW-1:0];
         dvd_ff   <= {dvd_ff[DIVIDEND_BITS-2:0], qbit};
         count_ff <= count_ff - 1'b1;
      end
   end
endmodule

[rtl/core/zbp_checker.sv]
// Port-level checks for zeromer_background_predict, attached by bind.
// Depends only on the top level's ports.
module zbp_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_estimate,
   input logic                   rsp_fault,
   input logic                   rsp_saturated
);
   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate)
         && $stable(rsp_fault) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // One frame in work: ready drops after every input transaction.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second frame taken while one is in work");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_estimate == '0)
      else $error("divide fault with nonzero estimate");
endmodule

bind zeromer_background_predict zbp_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_zbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_estimate  (rsp.zeromer_estimate),
   .rsp_fault     (rsp.divide_fault),
   .rsp_saturated (rsp.saturated)
);

[dv/zeromer_estimate_checker.sv]
// Scoreboard for the zeromer background predictor: tracks trace state, predicts
// one estimate per accepted frame and compares every result in order.
// Depends on zbp_pkg and the zbp_req_if / zbp_rsp_if channel interfaces.
module zeromer_estimate_checker #(
   parameter int FRACTION_BITS = 8,
   parameter int SAMPLE_BITS   = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [zbp_pkg::TAU_BITS-1:0] csr_write_data,
   zbp_req_if                           req,
   zbp_rsp_if                           rsp,
   output int unsigned                  fail_count,
   output int unsigned                  outstanding,
   output int unsigned                  checked,
   output int unsigned                  faults_seen,
   output int unsigned                  clips_seen
);
   localparam int TIME_BITS = zbp_pkg::TIME_BITS;
   localparam int TAU_BITS  = zbp_pkg::TAU_BITS;
   localparam int CORR_BITS = zbp_pkg::CORR_BITS;

   localparam longint EST_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint EST_MIN  = -EST_MAX - 1;
   localparam longint CORR_MAX = (longint'(1) <<< (CORR_BITS - 1)) - 1;
   localparam longint CORR_MIN = -CORR_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] estimate;
      logic                          fault;
      logic                          clipped;
   } estimate_type;

   estimate_type         expected_estimates[$];
   logic [TAU_BITS-1:0]  taue;
   longint               corr_sum;
   logic [TIME_BITS-1:0] prev_stamp;
   logic                 awaiting_first;

   function automatic estimate_type predict_estimate(
      input logic signed [SAMPLE_BITS-1:0] sample,
      input logic [TIME_BITS-1:0]          stamp,
      input logic [TAU_BITS-1:0]           taub,
      input logic                          last);
      estimate_type         r;
      logic [TIME_BITS-1:0] dt;
      longint               divisor;
      longint               quot;
      longint               corr_next;
      r = '0;
      if (!awaiting_first) begin
         dt = stamp - prev_stamp;   // modular, backward steps read as large
         divisor = longint'(taub) + longint'(dt);
         quot = 0;
         if (divisor == 0) begin
            r.fault = 1'b1;
         end else begin
            quot = (longint'(sample) * (longint'(taue) + longint'(dt))
                    + (corr_sum <<< FRACTION_BITS)) / divisor;
            if (quot > EST_MAX) begin
               quot = EST_MAX;
               r.clipped = 1'b1;
            end else if (quot < EST_MIN) begin
               quot = EST_MIN;
               r.clipped = 1'b1;
            end
         end
         r.estimate = quot[SAMPLE_BITS-1:0];
         corr_next = corr_sum + longint'(sample) - quot;
         if (corr_next > CORR_MAX) begin
            corr_next = CORR_MAX;
            r.clipped = 1'b1;
         end else if (corr_next < CORR_MIN) begin
            corr_next = CORR_MIN;
            r.clipped = 1'b1;
         end
         corr_sum = corr_next;
      end
      awaiting_first = 1'b0;
      prev_stamp = stamp;
      if (last) begin
         corr_sum = 0;
         prev_stamp = '0;
         awaiting_first = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < 50)
         $display("ERROR %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      estimate_type want;
      if (reset) begin
         taue = zbp_pkg::TAUE_RESET;
         corr_sum = 0;
         prev_stamp = '0;
         awaiting_first = 1'b1;
         expected_estimates.delete();
      end else begin
         // result first: it belongs to an earlier transaction than any frame taken now
         if (rsp.valid && rsp.ready) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch($sformatf("unexpected result, estimate %0d",
                                         rsp.zeromer_estimate));
            end else begin
               want = expected_estimates.pop_front();
               checked++;
               if (want.fault)
                  faults_seen++;
               if (want.clipped)
                  clips_seen++;
               if (rsp.zeromer_estimate !== want.estimate)
                  report_mismatch($sformatf("result %0d: estimate %0d, predicted %0d",
                                            checked, rsp.zeromer_estimate,
                                            $signed(want.estimate)));
               if (rsp.divide_fault !== want.fault)
                  report_mismatch($sformatf("result %0d: divide_fault %b, predicted %b",
                                            checked, rsp.divide_fault, want.fault));
               if (rsp.saturated !== want.clipped)
                  report_mismatch($sformatf("result %0d: saturated %b, predicted %b",
                                            checked, rsp.saturated, want.clipped));
            end
         end
         if (req.valid && req.ready)
            expected_estimates.push_back(predict_estimate(req.ref_sample, req.frame_time,
                                                          req.well_taub, req.last_frame));
         if (csr_write_enable)
            taue = csr_write_data;
      end
      outstanding = expected_estimates.size();
   end

endmodule

[dv/zeromer_background_predict_tb.sv]
// Testbench top for zeromer_background_predict: clock, reset, frame stimulus,
// result back-pressure and the verdict. Depends on zbp_pkg, the channel
// interfaces, the block itself and zeromer_estimate_checker.
module zeromer_background_predict_tb;
   localparam int FRACTION_BITS = 8;
   localparam int SAMPLE_BITS   = 24;
   localparam int TIME_BITS     = zbp_pkg::TIME_BITS;
   localparam int TAU_BITS      = zbp_pkg::TAU_BITS;
   localparam int CYCLE_LIMIT   = 500000;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int PHASES        = 6;
   localparam int PHASE_FRAMES  = 40;
   localparam int ACCUM_FRAMES  = 260;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [TAU_BITS-1:0] csr_write_data;
   logic                rsp_take = 1'b0;

   int unsigned fail_count, outstanding, checked, faults_seen, clips_seen;
   int unsigned frames_sent, traces_sent, taue_writes, burst_left;
   int unsigned cycle_count, ready_run, stall_run;

   zbp_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   zbp_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();

   assign rsp_ch.ready = rsp_take;

   zeromer_background_predict #(
      .FRACTION_BITS (FRACTION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   zeromer_estimate_checker #(
      .FRACTION_BITS (FRACTION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .checked          (checked),
      .faults_seen      (faults_seen),
      .clips_seen       (clips_seen)
   );

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("zeromer_background_predict: mismatch");
         $finish;
      end
   end

   // receiver: runs of ready, mostly followed by a stall of random length
   always @(negedge clock) begin
      if (stall_run != 0) begin
         rsp_take <= 1'b0;
         stall_run--;
      end else begin
         rsp_take <= 1'b1;
         if (ready_run != 0) begin
            ready_run--;
         end else begin
            ready_run = $urandom_range(1, 40);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_frame(input logic [SAMPLE_BITS-1:0] sample,
                             input logic [TIME_BITS-1:0]   stamp,
                             input logic [TAU_BITS-1:0]    taub,
                             input logic                   last);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      req_ch.valid      <= 1'b1;
      req_ch.ref_sample <= sample;
      req_ch.frame_time <= stamp;
      req_ch.well_taub  <= taub;
      req_ch.last_frame <= last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
      burst_left--;
      frames_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_taue(input logic [TAU_BITS-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      taue_writes++;
   endtask

   // well-formed trace: steady well constant but for occasional zero-taub frames, mostly forward steps of at most 8192
   task automatic run_trace(input int unsigned frames);
      logic [TIME_BITS-1:0]   stamp;
      logic [TIME_BITS-1:0]   step;
      logic [TAU_BITS-1:0]    well_tau;
      logic [TAU_BITS-1:0]    taub;
      logic [SAMPLE_BITS-1:0] sample;
      int unsigned            pick;
      stamp = TIME_BITS'($urandom);
      case ($urandom_range(0, 7))
         0:       well_tau = '0;
         1:       well_tau = '1;
         2:       well_tau = TAU_BITS'($urandom_range(1, 64));
         default: well_tau = TAU_BITS'($urandom);
      endcase
      for (int unsigned i = 0; i < frames; i++) begin
         pick = $urandom_range(0, 15);
         taub = well_tau;
         if (pick == 0) begin
            step = '0;
            taub = '0;
         end else if (pick == 1) begin
            step = '0;
         end else if (pick == 2) begin
            step = TIME_BITS'($urandom);
         end else if (pick < 6) begin
            step = TIME_BITS'($urandom_range(1, 64));
         end else begin
            step = TIME_BITS'($urandom_range(65, 8192));
         end
         stamp += step;
         case ($urandom_range(0, 15))
            0:       sample = SAMPLE_MAX;
            1:       sample = SAMPLE_MIN;
            2, 3:    sample = SAMPLE_BITS'($urandom);
            default: sample = SAMPLE_BITS'($urandom_range(0, 131071) - 65536);
         endcase
         send_frame(sample, stamp, taub, i == frames - 1);
      end
      traces_sent++;
   endtask

   // repeated timestamps with no buffering constant: every frame after the first faults and the
   // correction grows by nearly full scale until it clips
   task automatic run_accumulation(input logic positive);
      logic [TIME_BITS-1:0]   stamp;
      logic [SAMPLE_BITS-1:0] sample;
      stamp = TIME_BITS'($urandom);
      for (int i = 0; i < ACCUM_FRAMES; i++) begin
         sample = positive ? SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 65535))
                           : SAMPLE_MIN + SAMPLE_BITS'($urandom_range(0, 65535));
         send_frame(sample, stamp, '0, i == ACCUM_FRAMES - 1);
      end
      traces_sent++;
   endtask

   initial begin : stimulus
      int unsigned phase_end;
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.ref_sample <= '0;
      req_ch.frame_time <= '0;
      req_ch.well_taub  <= '0;
      req_ch.last_frame <= 1'b0;
      burst_left = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset taue: single-frame trace, zero divisor, clipping both ways, wraps
      send_frame(SAMPLE_MAX, 24'h000000, 16'hFFFF, 1'b1);
      send_frame(SAMPLE_MIN, 24'd1000, 16'd256, 1'b0);
      send_frame(24'd12345, 24'd1000, 16'd0, 1'b0);
      send_frame(SAMPLE_MAX, 24'd1256, 16'hFFFF, 1'b0);
      send_frame(SAMPLE_MIN, 24'd1257, 16'd0, 1'b0);
      send_frame(SAMPLE_MAX, 24'd1258, 16'd0, 1'b0);
      send_frame(-24'sd1, 24'd10, 16'd1, 1'b0);
      send_frame(-24'sd5, 24'hFFFFFF, 16'd3, 1'b0);
      send_frame(24'd7, 24'h000002, 16'd0, 1'b1);
      drain_results();

      // taue zero: negative quotients that truncate toward zero
      write_taue(16'h0000);
      send_frame(24'd0, 24'hABCDEF, 16'd0, 1'b0);
      send_frame(-24'sd5, 24'hABCDF2, 16'd1, 1'b0);
      send_frame(24'd5, 24'hABCDF5, 16'd1, 1'b0);
      send_frame(24'd0, 24'hABCDF5, 16'd0, 1'b1);
      drain_results();

      write_taue(16'hFFFF);
      send_frame(SAMPLE_MAX, 24'h000000, 16'hFFFF, 1'b0);
      send_frame(SAMPLE_MAX, 24'hFFFFFF, 16'hFFFF, 1'b0);
      send_frame(SAMPLE_MIN, 24'hFFFFFF, 16'h0000, 1'b0);
      send_frame(SAMPLE_MIN, 24'h000000, 16'h0000, 1'b1);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       write_taue(zbp_pkg::TAUE_RESET);
            1:       write_taue(TAU_BITS'($urandom_range(0, 255)));
            2:       write_taue(16'hFFFF);
            3:       write_taue(16'h0001);
            default: write_taue(TAU_BITS'($urandom));
         endcase
         phase_end = frames_sent + PHASE_FRAMES;
         while (frames_sent < phase_end) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: unrelated frames, last_frame at random
               repeat ($urandom_range(1, 6))
                  send_frame(SAMPLE_BITS'($urandom), TIME_BITS'($urandom),
                             TAU_BITS'($urandom), 1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 9) == 0) begin
               run_trace($urandom_range(20, 40));
            end else begin
               run_trace(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12));
            end
            if ($urandom_range(0, 9) == 0)
               drain_results();
         end
         drain_results();
      end

      write_taue(TAU_BITS'($urandom));
      run_accumulation(1'($urandom_range(0, 1)));
      drain_results();
      repeat (100) @(negedge clock);

      $display("%0d frames in %0d traces sent, taue written %0d times",
               frames_sent, traces_sent, taue_writes);
      $display("%0d estimates checked, %0d with divide fault, %0d clipped",
               checked, faults_seen, clips_seen);
      if (fail_count == 0 && outstanding == 0)
         $display("zeromer_background_predict: match");
      else
         $display("zeromer_background_predict: mismatch");
      $finish;
   end

endmodule

[zeromer_background_predict.f]
rtl/core/zbp_pkg.sv
rtl/core/zbp_req_if.sv
rtl/core/zbp_rsp_if.sv
rtl/core/zbp_serial_mult.sv
rtl/core/zbp_serial_div.sv
rtl/core/zeromer_background_predict.sv
rtl/core/zbp_checker.sv
dv/zeromer_estimate_checker.sv
dv/zeromer_background_predict_tb.sv
